### rtl/sf3_pkg.sv
// Shared types, constants and helper functions for the 3x3 stream filter.
// No dependencies; every other file of the block but sf3_ram refers to this package by scope.
package sf3_pkg;

    localparam int PIX_W         = 8;
    localparam int COEF_W        = 16;
    localparam int COEF_ROW_W    = 3 * COEF_W;
    localparam int CFG_WIDTH_W   = 11;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = COEF_ROW_W;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_FRAC_BITS = 8;
    localparam int MIN_WIDTH     = 3;
    localparam int WIN_TAPS      = 9;

    // 9-bit signed pixel times 16-bit coefficient, then sums of three and nine
    localparam int PROD_W   = PIX_W + 1 + COEF_W;
    localparam int ROWSUM_W = PROD_W + 2;
    localparam int SUM_W    = ROWSUM_W + 1;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_WIDTH_W-1:0] RESET_WIDTH   = CFG_WIDTH_W'(DEF_MAX_WIDTH);
    localparam logic                   FLIP_CONVOLVE = 1'b1;
    localparam logic [1:0]             ROW_FULL      = 2'd2;
    localparam logic [PIX_W-1:0]       PIX_MAX       = '1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_MASK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MIDDLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM = 3'd4;

    typedef logic [WIN_TAPS-1:0][PIX_W-1:0] t_window;   // row-major, tap 0 top left
    typedef logic [2:0][COEF_ROW_W-1:0]     t_coef_rows; // 0 top, 2 bottom

    typedef struct packed {
        logic valid;
        logic emit;
        logic last;
    } t_stage;

    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] data;
    } t_result;

    function automatic logic signed [COEF_W-1:0] coef_at(input logic [COEF_ROW_W-1:0] row,
                                                         input logic [1:0] pos);
        coef_at = $signed(row[pos*COEF_W +: COEF_W]);
    endfunction

endpackage

### rtl/sf3_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing; a read of the address being written returns the old word.
module sf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sf3_line_window.sv
// Row/column counters, the two line buffers (one RAM word per column) and the 3x3 window.
// Depends on sf3_pkg and sf3_ram.
module sf3_line_window #(
    parameter int MAX_WIDTH = sf3_pkg::DEF_MAX_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic [sf3_pkg::PIX_W-1:0]          i_pixel,
    input  logic                               i_frame_start,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]     i_width,
    output sf3_pkg::t_window                   o_window,
    output sf3_pkg::t_stage                    o_ctrl
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WU_W   = $clog2(MAX_WIDTH + 1);
    localparam int WORD_W = 2 * sf3_pkg::PIX_W;

    logic [COL_W-1:0]           r_col, n_col;
    logic [1:0]                 r_row, n_row;
    logic [COL_W-1:0]           col_base, col;
    logic [1:0]                 row_base;
    logic                       emit, last;

    logic                       r_s1_valid;
    logic                       r_s1_emit, r_s1_last;
    logic [sf3_pkg::PIX_W-1:0]  r_s1_px;
    logic [COL_W-1:0]           r_s1_col;
    logic                       r_fwd_hit;
    logic [WORD_W-1:0]          r_fwd_data;

    logic [WORD_W-1:0]          ram_rdata, line_word;
    logic [sf3_pkg::PIX_W-1:0]  up1, up2;

    sf3_pkg::t_window           r_win;
    sf3_pkg::t_stage            r_ctrl;

    // position of the incoming pixel
    always_comb begin
        col_base = i_frame_start ? '0 : r_col;
        row_base = i_frame_start ? '0 : r_row;
        if (WU_W'(col_base) >= i_width) begin
            col = COL_W'(i_width - WU_W'(1));
        end else begin
            col = col_base;
        end
        last = ((WU_W + 1)'(col) + (WU_W + 1)'(1)) >= (WU_W + 1)'(i_width);
        emit = (row_base >= sf3_pkg::ROW_FULL) && (col >= COL_W'(2));
        if (last) begin
            n_col = '0;
            n_row = (row_base < sf3_pkg::ROW_FULL) ? row_base + 2'd1 : row_base;
        end else begin
            n_col = col + COL_W'(1);
            n_row = row_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
            if (i_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_px   <= i_pixel;
            r_s1_col  <= col;
            r_s1_emit <= emit;
            r_s1_last <= last;
            // the column written this cycle is read back stale by the RAM: bypass it
            r_fwd_hit  <= r_s1_valid && (col == r_s1_col);
            r_fwd_data <= {r_s1_px, up1};
        end
    end

    // word layout: previous row in the upper byte, the row before it in the lower
    sf3_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata ({r_s1_px, up1}),
        .i_re    (i_accept),
        .i_raddr (col),
        .o_rdata (ram_rdata)
    );

    assign line_word = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign up1       = line_word[WORD_W-1:sf3_pkg::PIX_W];
    assign up2       = line_word[sf3_pkg::PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_ctrl <= '0;
        end else begin
            r_ctrl.valid <= r_s1_valid;
            r_ctrl.emit  <= r_s1_emit;
            r_ctrl.last  <= r_s1_last;
            if (r_s1_valid) begin
                // shift the window left and load the new column
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= up2;
                r_win[3] <= r_win[4];
                r_win[4] <= r_win[5];
                r_win[5] <= up1;
                r_win[6] <= r_win[7];
                r_win[7] <= r_win[8];
                r_win[8] <= r_s1_px;
            end
        end
    end

    assign o_window = r_win;
    assign o_ctrl   = r_ctrl;

endmodule

### rtl/sf3_mac.sv
// Multiply-accumulate pipeline: nine products, three row sums, then total, floor and clamp.
// Depends on sf3_pkg.
module sf3_mac #(
    parameter int FRAC_BITS = sf3_pkg::DEF_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sf3_pkg::t_window           i_window,
    input  sf3_pkg::t_stage            i_ctrl,
    input  logic                       i_flip,
    input  sf3_pkg::t_coef_rows        i_coef,
    output sf3_pkg::t_stage            o_done,
    output logic [sf3_pkg::PIX_W-1:0]  o_filtered
);

    localparam int PROD_W   = sf3_pkg::PROD_W;
    localparam int ROWSUM_W = sf3_pkg::ROWSUM_W;
    localparam int SUM_W    = sf3_pkg::SUM_W;

    logic signed [sf3_pkg::COEF_W-1:0] coef  [sf3_pkg::WIN_TAPS];
    logic signed [PROD_W-1:0]          r_prod [sf3_pkg::WIN_TAPS];
    logic signed [ROWSUM_W-1:0]        r_rsum [3];
    logic signed [SUM_W-1:0]           total, shifted;
    sf3_pkg::t_stage                   r_p, r_r;

    // pick the coefficient of each tap, rotated 180 degrees when i_flip selects convolution
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (i_flip == sf3_pkg::FLIP_CONVOLVE) begin
                    coef[i*3+j] = sf3_pkg::coef_at(i_coef[2-i], 2'(2 - j));
                end else begin
                    coef[i*3+j] = sf3_pkg::coef_at(i_coef[i], 2'(j));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < sf3_pkg::WIN_TAPS; k++) begin
            r_prod[k] <= PROD_W'($signed({1'b0, i_window[k]})) * PROD_W'(coef[k]);
        end
        for (int r = 0; r < 3; r++) begin
            r_rsum[r] <= ROWSUM_W'(r_prod[r*3]) + ROWSUM_W'(r_prod[r*3+1])
                       + ROWSUM_W'(r_prod[r*3+2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= '0;
            r_r <= '0;
        end else begin
            r_p <= i_ctrl;
            r_r <= r_p;
        end
    end

    always_comb begin
        total   = SUM_W'(r_rsum[0]) + SUM_W'(r_rsum[1]) + SUM_W'(r_rsum[2]);
        shifted = total >>> FRAC_BITS;
        if (total < 0) begin
            o_filtered = '0;
        end else if (shifted[SUM_W-1:sf3_pkg::PIX_W] != '0) begin
            o_filtered = sf3_pkg::PIX_MAX;
        end else begin
            o_filtered = shifted[sf3_pkg::PIX_W-1:0];
        end
    end

    assign o_done = r_r;

endmodule

### rtl/sf3_fifo.sv
// Small register FIFO that holds finished results until the downstream side takes them.
// Depends on sf3_pkg.
module sf3_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  sf3_pkg::t_result             i_data,
    input  logic                         i_ready,
    output logic                         o_valid,
    output sf3_pkg::t_result             o_data,
    output logic [sf3_pkg::FIFO_CW-1:0]  o_count
);

    sf3_pkg::t_result               r_mem [sf3_pkg::FIFO_DEPTH];
    logic [sf3_pkg::FIFO_AW-1:0]    r_wr, r_rd;
    logic [sf3_pkg::FIFO_CW-1:0]    r_count;
    logic                           pop;

    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + sf3_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + sf3_pkg::FIFO_AW'(1);
            end
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + sf3_pkg::FIFO_CW'(1);
                2'b01:   r_count <= r_count - sf3_pkg::FIFO_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

### rtl/stream_filter_3x3.sv
// 3x3 filter over a padded 8-bit greyscale stream: gives one result per interior pixel.
// Throughput is one pixel per cycle while s_axis_tready is high, set by the single
// line-buffer RAM (one read and one write port, one word per column holding both previous
// rows); results pass the input, window, product and row-sum registers into an eight-entry
// output FIFO that drives m_axis_tvalid, and s_axis_tready drops only when that FIFO and
// the pipeline together are full. The line buffers have no reset and no clearing pass;
// they are fully written by the first two rows of each frame before any result is formed.
// Depends on sf3_pkg, sf3_line_window, sf3_mac, sf3_fifo and sf3_ram.
module stream_filter_3x3 #(
    parameter int MAX_WIDTH = sf3_pkg::DEF_MAX_WIDTH,
    parameter int FRAC_BITS = sf3_pkg::DEF_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sf3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sf3_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // pixel input
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] pixel
    input  logic                             s_axis_tuser,  // [0] frame_start
    // filtered output
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // [7:0] filtered
    output logic                             m_axis_tlast   // row_end
);

    localparam int WU_W  = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WU_W > sf3_pkg::CFG_WIDTH_W) ? WU_W : sf3_pkg::CFG_WIDTH_W;
    localparam int OCC_W = sf3_pkg::FIFO_CW + 1;

    logic [sf3_pkg::CFG_WIDTH_W-1:0] r_image_width;
    logic                            r_flip_mask;
    sf3_pkg::t_coef_rows             r_coef;
    logic                            cfg_we;

    logic [CMP_W-1:0]                width_wide;
    logic [WU_W-1:0]                 width_used;

    logic                            accept;
    sf3_pkg::t_window                window;
    sf3_pkg::t_stage                 win_ctrl, done;
    logic [sf3_pkg::PIX_W-1:0]       filtered;
    sf3_pkg::t_result                push_data, head;
    logic [sf3_pkg::FIFO_CW-1:0]     fifo_count;
    logic [sf3_pkg::FIFO_CW-1:0]     r_inflight;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= sf3_pkg::RESET_WIDTH;
            r_flip_mask   <= 1'b0;
            r_coef        <= '0;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                sf3_pkg::REG_IMAGE_WIDTH: r_image_width <= i_cfg_data[sf3_pkg::CFG_WIDTH_W-1:0];
                sf3_pkg::REG_FLIP_MASK:   r_flip_mask   <= i_cfg_data[0];
                sf3_pkg::REG_COEF_TOP:    r_coef[0]     <= i_cfg_data;
                sf3_pkg::REG_COEF_MIDDLE: r_coef[1]     <= i_cfg_data;
                sf3_pkg::REG_COEF_BOTTOM: r_coef[2]     <= i_cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // clamp the programmed width to 3..MAX_WIDTH
    always_comb begin
        width_wide = CMP_W'(r_image_width);
        if (width_wide < CMP_W'(sf3_pkg::MIN_WIDTH)) begin
            width_used = WU_W'(sf3_pkg::MIN_WIDTH);
        end else if (width_wide > CMP_W'(MAX_WIDTH)) begin
            width_used = WU_W'(MAX_WIDTH);
        end else begin
            width_used = WU_W'(width_wide);
        end
    end

    // hold off input once every FIFO slot is spoken for by stored or in-flight items
    assign s_axis_tready = (OCC_W'(fifo_count) + OCC_W'(r_inflight))
                         < OCC_W'(sf3_pkg::FIFO_DEPTH);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            unique case ({accept, done.valid})
                2'b10:   r_inflight <= r_inflight + sf3_pkg::FIFO_CW'(1);
                2'b01:   r_inflight <= r_inflight - sf3_pkg::FIFO_CW'(1);
                default: r_inflight <= r_inflight;
            endcase
        end
    end

    sf3_line_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_pixel       (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .i_width       (width_used),
        .o_window      (window),
        .o_ctrl        (win_ctrl)
    );

    sf3_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_window   (window),
        .i_ctrl     (win_ctrl),
        .i_flip     (r_flip_mask),
        .i_coef     (r_coef),
        .o_done     (done),
        .o_filtered (filtered)
    );

    assign push_data.last = done.last;
    assign push_data.data = filtered;

    sf3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (done.valid && done.emit),
        .i_data  (push_data),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (head),
        .o_count (fifo_count)
    );

    assign m_axis_tdata = head.data;
    assign m_axis_tlast = head.last;

endmodule
